// File: hw/rtl/bva_pkg.sv
// ----------------------------------------------------------------------------
// bva_pkg
// shared widths and constants of the battery voltage averager
// ----------------------------------------------------------------------------
package bva_pkg;

  localparam int AVG_W       = 12;
  localparam int LEVEL_W     = 8;
  localparam int PCT_W       = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // one quotient bit per divider step
  localparam int DIV_STEPS = AVG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(200);
  localparam logic [AVG_W-1:0]   THR_RESET = AVG_W'(2000);
  localparam logic [AVG_W-1:0]   SAMPLE_MAX = AVG_W'(4095);

  typedef logic [AVG_W-1:0]   mv_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [PCT_W-1:0]   pct_t;

endpackage

// File: hw/rtl/bva_divider.sv
// ----------------------------------------------------------------------------
// bva_divider
// bit-serial restoring divider, one quotient bit per cycle, quotient < 2^12
// ----------------------------------------------------------------------------
module bva_divider #(
  parameter int HI_W = 9
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [HI_W+bva_pkg::AVG_W-1:0]   dividend,
  input  logic [HI_W:0]                    divisor,
  output logic                             busy,
  output bva_pkg::mv_t                     quotient
);
  import bva_pkg::*;

  logic                busy_r;
  logic [STEP_W-1:0]   step_r;
  logic [HI_W-1:0]     rem_r;
  logic [AVG_W-1:0]    dq_r;
  logic [HI_W:0]       divisor_r;

  logic [HI_W:0]       trial;
  logic                ge;
  logic [HI_W:0]       diff;

  // shift in next dividend bit, compare against divisor
  assign trial = {rem_r, dq_r[AVG_W-1]};
  assign ge    = (trial >= divisor_r);
  assign diff  = trial - divisor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= dividend[HI_W+AVG_W-1:AVG_W];
      dq_r      <= dividend[AVG_W-1:0];
      divisor_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[HI_W-1:0] : trial[HI_W-1:0];
      dq_r  <= {dq_r[AVG_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

// File: hw/rtl/bva_level.sv
// ----------------------------------------------------------------------------
// bva_level
// battery level and percent from average and threshold
// ----------------------------------------------------------------------------
module bva_level (
  input  bva_pkg::mv_t    average,
  input  bva_pkg::mv_t    threshold,
  output bva_pkg::level_t level,
  output bva_pkg::pct_t   percent
);
  import bva_pkg::*;

  logic [AVG_W:0]   diff;
  logic [AVG_W-3:0] quarter;
  level_t           level_c;

  assign diff    = {1'b0, average} - {1'b0, threshold};
  assign quarter = diff[AVG_W-1:2];

  always_comb begin
    level_c = '0;
    if (average > threshold) begin
      if (quarter > (AVG_W-2)'(LEVEL_MAX)) begin
        level_c = LEVEL_MAX;
      end else begin
        level_c = quarter[LEVEL_W-1:0];
      end
    end
  end

  assign level   = level_c;
  assign percent = level_c[LEVEL_W-1:1];

endmodule

// File: hw/rtl/battery_voltage_averager.sv
// ----------------------------------------------------------------------------
// battery_voltage_averager
// running average of battery voltage samples with level, percent and
// undervoltage flag
// ----------------------------------------------------------------------------
// Each input word carries one 12-bit millivolt sample. It is added to a
// running sum; while fewer than 2^AVERAGE_SHIFT samples have been taken the
// average is the cumulative mean, afterwards the sum leaks by its own
// average each sample, giving an exponential average. Every sample yields
// one output word. After the sample is accepted, the bit-serial divider forms
// the average one bit per cycle, the control then leaves the divide state,
// and the write-back state writes the output register. The input is ready
// again only once the state has returned to idle, so a new sample is not
// accepted before the last one has been written out. If the output register
// still holds a word that has not been taken, a finished sample waits for it,
// and the input stays stalled until that word leaves.
module battery_voltage_averager #(
  parameter int AVERAGE_SHIFT = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [11:0] sample_mv
  input  logic [bva_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [11:0] avg_mv, [19:12] level, [26:20] percent, [27] undervoltage
  output logic [bva_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_wen,
  input  logic [bva_pkg::AVG_W-1:0]       cfg_wdata
);
  import bva_pkg::*;

  localparam int SUM_W = AVG_W + AVERAGE_SHIFT;
  localparam int CNT_W = AVERAGE_SHIFT + 1;
  localparam logic [SUM_W-1:0] SUM_MAX =
    SUM_W'((64'd1 << AVERAGE_SHIFT) * 64'(SAMPLE_MAX));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WB
  } state_t;

  state_t           state_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  mv_t              thr_r;
  logic             uv_r;
  logic             out_valid_r;
  mv_t              out_avg_r;
  level_t           out_level_r;
  pct_t             out_pct_r;
  logic             out_uv_r;

  logic             in_acc;
  mv_t              sample;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_free;
  logic             wb_fire;
  logic             div_busy;
  mv_t              quotient;
  level_t           level;
  pct_t             percent;

  assign sample   = in_tdata[AVG_W-1:0];
  assign in_acc   = in_tvalid && in_tready;
  assign sum_nxt  = sum_r + SUM_W'(sample);
  assign cnt_nxt  = cnt_r + 1'b1;
  assign out_free = !out_valid_r || out_tready;
  assign wb_fire  = (state_r == ST_WB) && out_free;

  bva_divider #(
    .HI_W (AVERAGE_SHIFT)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (sum_nxt),
    .divisor  (cnt_nxt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  bva_level u_level (
    .average   (quotient),
    .threshold (thr_r),
    .level     (level),
    .percent   (percent)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wen) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wb_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            sum_r   <= sum_nxt;
            cnt_r   <= cnt_nxt;
            uv_r    <= (sample < thr_r);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!div_busy) begin
            state_r <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_free) begin
            out_avg_r   <= quotient;
            out_level_r <= level;
            out_pct_r   <= percent;
            out_uv_r    <= uv_r;
            // full window: leak the average back out of the sum
            if (cnt_r[AVERAGE_SHIFT]) begin
              sum_r <= sum_r - SUM_W'(quotient);
              cnt_r <= cnt_r - 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - AVG_W - LEVEL_W - PCT_W - 1){1'b0}},
                       out_uv_r, out_pct_r, out_level_r, out_avg_r};

`ifndef SYNTHESIS
  a_count_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cnt_r[AVERAGE_SHIFT])
    else $error("sample count reached full window between words");

  a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_MAX)
    else $error("running sum exceeds window capacity");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (div_busy && (state_r == ST_DIV)))
    else $error("divider not started on accepted word");
`endif

endmodule

// File: test/tb_battery_voltage_averager.sv
// ----------------------------------------------------------------------------
// tb_battery_voltage_averager
// self-checking testbench for the battery voltage averager
// ----------------------------------------------------------------------------
// Drives millivolt samples into the input stream and predicts every output
// word from its own copy of the running sum, the sample count and the
// threshold. The run starts with a directed set of edge values, then random
// phases with different thresholds, random gaps on both streams, a long
// output stall that backs up the input, and pauses until all words are back.
// ----------------------------------------------------------------------------
module tb_battery_voltage_averager;
  import bva_pkg::*;

  localparam int AVG_SHIFT   = 9;
  localparam int LEVEL_SHIFT = 2;
  localparam int LEVEL_LSB   = AVG_W;
  localparam int PCT_LSB     = LEVEL_LSB + LEVEL_W;
  localparam int UV_BIT      = PCT_LSB + PCT_W;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    mv_t    average;
    level_t level;
    pct_t   percent;
    logic   undervoltage;
  } battery_word_t;

  class battery_scoreboard;
    int unsigned   sample_sum;
    int unsigned   sample_count;
    mv_t           threshold;
    battery_word_t expected_words[$];
    int            mismatch_count;
    int            word_index;

    function new();
      sample_sum     = 0;
      sample_count   = 0;
      threshold      = THR_RESET;
      mismatch_count = 0;
      word_index     = 0;
    endfunction

    function void note_sample(mv_t mv);
      battery_word_t e;
      int unsigned   avg;
      int unsigned   lvl;
      sample_sum   += mv;
      sample_count += 1;
      if (sample_count >= (1 << AVG_SHIFT)) begin
        avg = sample_sum >> AVG_SHIFT;
        sample_sum   -= avg;
        sample_count -= 1;
      end else begin
        avg = sample_sum / sample_count;
      end
      e.average = mv_t'(avg);
      lvl = 0;
      if (e.average > threshold) begin
        lvl = (int'(e.average) - int'(threshold)) >> LEVEL_SHIFT;
        if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
      end
      e.level        = level_t'(lvl);
      e.percent      = pct_t'(lvl >> 1);
      e.undervoltage = (mv < threshold);
      expected_words.push_back(e);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("word %0d: %s got %0d expected %0d", word_index, field, got, want);
    endtask

    task check_word(logic [OUT_TDATA_W-1:0] w);
      battery_word_t e;
      word_index++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", w, 0);
        return;
      end
      e = expected_words.pop_front();
      if (w[AVG_W-1:0] !== e.average)
        report_mismatch("avg_mv", w[AVG_W-1:0], e.average);
      if (w[PCT_LSB-1:LEVEL_LSB] !== e.level)
        report_mismatch("level", w[PCT_LSB-1:LEVEL_LSB], e.level);
      if (w[UV_BIT-1:PCT_LSB] !== e.percent)
        report_mismatch("percent", w[UV_BIT-1:PCT_LSB], e.percent);
      if (w[UV_BIT] !== e.undervoltage)
        report_mismatch("undervoltage", w[UV_BIT], e.undervoltage);
      if (w[OUT_TDATA_W-1:UV_BIT+1] !== '0)
        report_mismatch("padding", w[OUT_TDATA_W-1:UV_BIT+1], 0);
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wen;
  mv_t                    cfg_wdata;

  battery_scoreboard sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;

  battery_voltage_averager #(
    .AVERAGE_SHIFT(AVG_SHIFT)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int pick_gap(int idle_pct);
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(mv_t mv);
    int gap;
    in_tdata  = IN_TDATA_W'(mv);
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(mv);
    @(negedge clk);
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata  = IN_TDATA_W'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_threshold(mv_t thr);
    drain_results();
    cfg_wen   = 1'b1;
    cfg_wdata = thr;
    sb.threshold = thr;
    @(negedge clk);
    cfg_wen   = 1'b0;
    cfg_wdata = mv_t'($urandom);
  endtask

  function automatic mv_t pick_sample(mv_t thr);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 50) v = int'(thr) + int'($urandom_range(0, 128)) - 64;
    else if (r < 80) v = $urandom_range(0, SAMPLE_MAX);
    else if (r < 90) v = int'(thr) + int'($urandom_range(700, 900));
    else v = $urandom_range(0, 1) ? int'(SAMPLE_MAX) : 0;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return mv_t'(v);
  endfunction

  task automatic run_phase(int n_items, mv_t thr, int tx_pct, int rx_pct, bit long_hold);
    write_threshold(thr);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (long_hold) hold_req++;
    for (int i = 0; i < n_items; i++) begin
      // let everything come back once in the middle of the phase
      if (i == n_items / 2) drain_results();
      send_sample(pick_sample(thr));
    end
  endtask

  // receiver: random backpressure and a long hold-off on request
  initial begin
    int hold_seen;
    int stall_left;
    hold_seen  = 0;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen  = hold_req;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        stall_left = pick_gap(rx_idle_pct);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    mv_t directed_mv[$];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wen     = 1'b0;
    cfg_wdata   = '0;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    hold_req    = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset threshold: extremes, exact threshold, one either side, bit patterns
    directed_mv = '{12'd0, 12'd4095, 12'd2000, 12'd1999, 12'd2001, 12'd4095,
                    12'd4095, 12'd0, 12'd1, 12'd2730, 12'd1365};
    foreach (directed_mv[i]) send_sample(directed_mv[i]);

    // zero threshold: no undervoltage possible, level clamps
    write_threshold(12'd0);
    directed_mv = '{12'd0, 12'd4095, 12'd4095, 12'd4095};
    foreach (directed_mv[i]) send_sample(directed_mv[i]);

    // full-scale threshold: level always zero
    write_threshold(12'd4095);
    directed_mv = '{12'd4094, 12'd4095, 12'd0};
    foreach (directed_mv[i]) send_sample(directed_mv[i]);

    write_threshold(12'd1500);
    directed_mv = '{12'd1499, 12'd1500, 12'd4095};
    foreach (directed_mv[i]) send_sample(directed_mv[i]);

    run_phase(300, mv_t'($urandom_range(0, 4095)), 20, 20, 1'b0);
    run_phase(300, mv_t'($urandom_range(0, 4095)), 0, 0, 1'b0);
    run_phase(300, mv_t'($urandom_range(500, 3500)), 0, 10, 1'b1);
    run_phase(300, mv_t'($urandom_range(0, 4095)), 40, 40, 1'b0);
    run_phase(150, 12'd0, 15, 15, 1'b0);
    run_phase(150, 12'd4095, 15, 15, 1'b0);
    run_phase(300, THR_RESET, 25, 5, 1'b0);

    drain_results();
    repeat (40) @(negedge clk);
    if (sb.mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
